[src/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, status codes and the CRC-16 byte update for the Modbus RTU
// response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frame_length;
        logic [31:0] value_word;
        logic [15:0] second_word;
        logic [15:0] third_word;
    } t_out_beat;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_CRC_BAD = 2'd2;

    localparam logic [15:0] CRC_PRESET       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  MIN_LENGTH_RESET = 8'd9;
    localparam logic [7:0]  COUNT_MAX        = 8'hFF;

    // Reflected CRC-16 update for one byte, unrolled over its eight bits.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[src/modbus_rtu_response_checker.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks received Modbus RTU response frames byte by byte: CRC-16, minimum
// length, and capture of three data words at fixed byte positions.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in_beat)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out_beat)
//   cfg       input      i_cfg_we                   i_cfg_data (min_length)
//
// One byte beat is accepted per cycle while o_in_stall is low. The input
// register holds it; the frame logic evaluates it and, on the last byte, loads the
// result register, so a result follows its final byte through both registers.
// Reset returns the frame state to empty and min_length to 9.
// A stalled result blocks only end-of-frame beats; other bytes keep flowing.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mrc_pkg::t_in_beat  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mrc_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);
    import mrc_pkg::*;

    logic      r_out_valid;
    t_out_beat r_out_data;
    logic [7:0] r_min_length;
    logic      beat_valid;
    t_in_beat  beat;
    logic      out_free;
    logic      advance;
    t_out_beat result;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = beat_valid && (!beat.end_of_frame || out_free);

    mrc_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_advance   (advance),
        .o_in_stall  (o_in_stall),
        .o_beat_valid(beat_valid),
        .o_beat      (beat)
    );

    mrc_frame_eval u_frame_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_beat      (beat),
        .i_min_length(r_min_length),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_min_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && beat.end_of_frame) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && beat.end_of_frame) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/mrc_in_stage.sv]
// ----------------------------------------------------------------------------
// mrc_in_stage
// Input register: holds one accepted byte beat until the frame logic takes it.
// ----------------------------------------------------------------------------
module mrc_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mrc_pkg::t_in_beat i_in_data,
    input  logic             i_advance,
    output logic             o_in_stall,
    output logic             o_beat_valid,
    output mrc_pkg::t_in_beat o_beat
);
    import mrc_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;
    logic     n_accept;

    // The register can be refilled in the same cycle that its beat moves on.
    assign o_in_stall = r_valid && !i_advance;
    assign n_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_beat <= i_in_data;
        end
    end

    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

endmodule

[src/mrc_frame_eval.sv]
// ----------------------------------------------------------------------------
// mrc_frame_eval
// Per-frame state: delay line, CRC, byte count and data captures, plus the
// end-of-frame status and result word evaluation.
// ----------------------------------------------------------------------------
module mrc_frame_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mrc_pkg::t_in_beat i_beat,
    input  logic [7:0]        i_min_length,
    output mrc_pkg::t_out_beat o_result
);
    import mrc_pkg::*;

    logic [15:0] r_crc,  n_crc;
    logic [7:0]  r_dly0, n_dly0;
    logic [7:0]  r_dly1, n_dly1;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_long, n_long;
    logic [15:0] r_mid,  n_mid;
    logic [15:0] r_tail, n_tail;
    logic [1:0]  n_status;

    always_comb begin
        // The CRC trails the input by two bytes, fed from the delay line.
        n_crc  = (r_count >= 8'd2) ? crc_byte(r_crc, r_dly1) : r_crc;
        n_dly1 = r_dly0;
        n_dly0 = i_beat.rx_byte;

        n_long = r_long;
        n_mid  = r_mid;
        n_tail = r_tail;
        if (r_count >= 8'd3 && r_count <= 8'd6) begin
            n_long = {r_long[23:0], i_beat.rx_byte};
        end else if (r_count == 8'd15 || r_count == 8'd16) begin
            n_mid = {r_mid[7:0], i_beat.rx_byte};
        end else if (r_count == 8'd19 || r_count == 8'd20) begin
            n_tail = {r_tail[7:0], i_beat.rx_byte};
        end

        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 8'd1;

        if (n_count < i_min_length) begin
            n_status = ST_SHORT;
        end else if (n_crc[7:0] == n_dly1 && n_crc[15:8] == n_dly0) begin
            n_status = ST_GOOD;
        end else begin
            n_status = ST_CRC_BAD;
        end

        o_result.status       = n_status;
        o_result.frame_length = n_count;
        o_result.value_word   = (n_status == ST_GOOD) ? n_long : 32'd0;
        o_result.second_word  = (n_status == ST_GOOD) ? n_mid  : 16'd0;
        o_result.third_word   = (n_status == ST_GOOD) ? n_tail : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_beat.end_of_frame)) begin
            r_crc   <= CRC_PRESET;
            r_dly0  <= 8'd0;
            r_dly1  <= 8'd0;
            r_count <= 8'd0;
            r_long  <= 32'd0;
            r_mid   <= 16'd0;
            r_tail  <= 16'd0;
        end else if (i_fire) begin
            r_crc   <= n_crc;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_count <= n_count;
            r_long  <= n_long;
            r_mid   <= n_mid;
            r_tail  <= n_tail;
        end
    end

endmodule

[src/mrc_checker.sv]
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks for the Modbus RTU response checker, bound to the top.
// ----------------------------------------------------------------------------
module mrc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input mrc_pkg::t_out_beat o_out_data,
    input logic               i_out_stall
);
    import mrc_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_GOOD ||
                         o_out_data.status == ST_SHORT ||
                         o_out_data.status == ST_CRC_BAD))
        else $error("unused status code reported");

    a_bad_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_GOOD |->
            o_out_data.value_word == 32'd0 && o_out_data.second_word == 16'd0 &&
            o_out_data.third_word == 16'd0)
        else $error("data words not cleared on a failed frame");

    // A good frame needs at least the two CRC bytes.
    a_good_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_GOOD |-> o_out_data.frame_length >= 8'd2)
        else $error("good frame shorter than its CRC");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .o_out_data (o_out_data),
    .i_out_stall(i_out_stall)
);

[tb/tb_modbus_rtu_response_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_checker
// Sends Modbus RTU response frames to the checker one byte beat at a time.
// Frames are well formed, CRC-corrupted or random noise, with lengths from one
// byte to past the 255 count limit, under several min_length settings. A
// byte-level model in the bench predicts each frame verdict, and every result
// beat is compared field by field against it. Both sides idle at random, and
// the receiver holds off long enough once to back the block up.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_checker;
    import mrc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {FR_GOOD, FR_CORRUPT, FR_NOISE} frame_kind_e;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    t_in_beat   in_beat;
    logic       in_stall;
    logic       out_valid;
    t_out_beat  out_beat;
    logic       out_stall;
    logic       cfg_we;
    logic [7:0] cfg_data;

    // Frame state of the bench model.
    logic [15:0] fm_crc;
    logic [7:0]  fm_recent;
    logic [7:0]  fm_older;
    logic [7:0]  fm_count;
    logic [7:0]  fm_min_length;
    logic [31:0] fm_long;
    logic [15:0] fm_mid;
    logic [15:0] fm_tail;

    t_out_beat   frame_verdicts_q[$];
    logic [7:0]  frame_bytes[$];

    int errors = 0;
    int cycle_count = 0;
    int bytes_accepted = 0;
    int n_good = 0;
    int n_short = 0;
    int n_crc_bad = 0;
    int rx_hold_left = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    modbus_rtu_response_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_beat),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // LSB-first CRC-16, one data bit per step.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[15:1]};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic clear_frame_model();
        fm_crc    = CRC_PRESET;
        fm_recent = 8'h00;
        fm_older  = 8'h00;
        fm_count  = 8'h00;
        fm_long   = 32'h0;
        fm_mid    = 16'h0;
        fm_tail   = 16'h0;
    endtask

    // Advances the model by one accepted byte and queues the verdict on the last one.
    task automatic track_rx_byte(input t_in_beat beat);
        logic [7:0] pos;
        t_out_beat  verdict;
        pos = fm_count;
        // The CRC trails the input by two bytes; the oldest byte leaves the delay line.
        if (pos >= 8'd2) begin
            fm_crc = crc16_fold(fm_crc, fm_older);
        end
        fm_older  = fm_recent;
        fm_recent = beat.rx_byte;
        if (pos >= 8'd3 && pos <= 8'd6) begin
            fm_long = {fm_long[23:0], beat.rx_byte};
        end else if (pos == 8'd15 || pos == 8'd16) begin
            fm_mid = {fm_mid[7:0], beat.rx_byte};
        end else if (pos == 8'd19 || pos == 8'd20) begin
            fm_tail = {fm_tail[7:0], beat.rx_byte};
        end
        if (fm_count != COUNT_MAX) begin
            fm_count++;
        end
        if (beat.end_of_frame) begin
            verdict = '0;
            verdict.frame_length = fm_count;
            if (fm_count < fm_min_length) begin
                verdict.status = ST_SHORT;
            end else if (fm_crc[7:0] == fm_older && fm_crc[15:8] == fm_recent) begin
                verdict.status      = ST_GOOD;
                verdict.value_word  = fm_long;
                verdict.second_word = fm_mid;
                verdict.third_word  = fm_tail;
            end else begin
                verdict.status = ST_CRC_BAD;
            end
            frame_verdicts_q.push_back(verdict);
            clear_frame_model();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Checks result beats against the oldest verdict, then tracks input bytes and writes.
    always @(posedge clk) begin : verdict_check
        t_out_beat want;
        if (!rst_n) begin
            fm_min_length = MIN_LENGTH_RESET;
            clear_frame_model();
        end else begin
            if (out_valid && !out_stall) begin
                if (frame_verdicts_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, out_beat);
                    errors++;
                end else begin
                    want = frame_verdicts_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(out_beat.status));
                    compare_field("frame_length", 32'(want.frame_length),
                                  32'(out_beat.frame_length));
                    compare_field("value_word", want.value_word, out_beat.value_word);
                    compare_field("second_word", 32'(want.second_word),
                                  32'(out_beat.second_word));
                    compare_field("third_word", 32'(want.third_word),
                                  32'(out_beat.third_word));
                    case (want.status)
                        ST_GOOD:  n_good++;
                        ST_SHORT: n_short++;
                        default:  n_crc_bad++;
                    endcase
                end
            end
            if (in_valid && !in_stall) begin
                bytes_accepted++;
                track_rx_byte(in_beat);
            end
            if (cfg_we) begin
                fm_min_length = cfg_data;
            end
        end
    end

    // Receiver side: random stall bursts, plus a long hold-off when one is requested.
    initial begin : receiver
        int burst_left;
        burst_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_left > 0) begin
                out_stall <= 1'b1;
                rx_hold_left--;
            end else if (burst_left > 0) begin
                out_stall <= 1'b1;
                burst_left--;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                out_stall  <= 1'b1;
                burst_left = $urandom_range(0, 7);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one byte beat, with an occasional idle burst first, and waits for acceptance.
    task automatic send_beat(input logic [7:0] b, input logic eof);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{rx_byte: b, end_of_frame: eof};
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic fill_frame(input int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Overwrites the last two bytes with the correct CRC over the bytes before them, low byte first.
    task automatic seal_frame();
        logic [15:0] crc;
        int          n;
        n   = frame_bytes.size();
        crc = CRC_PRESET;
        for (int i = 0; i < n - 2; i++) begin
            crc = crc16_fold(crc, frame_bytes[i]);
        end
        if (n >= 2) begin
            frame_bytes[n-2] = crc[7:0];
            frame_bytes[n-1] = crc[15:8];
        end
    endtask

    task automatic make_frame(input int len, input frame_kind_e kind);
        int idx;
        fill_frame(len);
        if (kind != FR_NOISE) begin
            seal_frame();
        end
        if (kind == FR_CORRUPT) begin
            idx = $urandom_range(0, len - 1);
            frame_bytes[idx][$urandom_range(0, 7)] ^= 1'b1;
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (frame_verdicts_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_min_length(input logic [7:0] value);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_default_length();
        fill_frame(9);
        frame_bytes[0] = 8'h00;
        frame_bytes[1] = 8'hFF;
        seal_frame();
        send_frame();
    endtask

    task automatic test_short_and_crc_error();
        make_frame(3, FR_GOOD);
        send_frame();
        make_frame(9, FR_CORRUPT);
        send_frame();
    endtask

    // With no minimum, a one-byte frame compares against empty delay slots and a
    // two-byte frame is checked against the untouched preset.
    task automatic test_tiny_frames();
        set_min_length(8'd0);
        make_frame(1, FR_NOISE);
        send_frame();
        make_frame(2, FR_GOOD);
        send_frame();
    endtask

    task automatic test_random_frames(input logic [7:0] min_len, input int n_bytes);
        int          sent;
        int          len;
        int          pick;
        frame_kind_e kind;
        set_min_length(min_len);
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                len = $urandom_range(1, 3);
            end else if (pick < 75) begin
                len = $urandom_range(4, 16);
            end else begin
                len = $urandom_range(17, 40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                kind = FR_GOOD;
            end else if (pick < 85) begin
                kind = FR_CORRUPT;
            end else begin
                kind = FR_NOISE;
            end
            make_frame(len, kind);
            send_frame();
            sent += len;
        end
    endtask

    // Short frames pile up behind a receiver that holds off, so end-of-frame beats stall.
    task automatic test_backpressure();
        set_min_length(8'd4);
        tx_idle_en   = 1'b0;
        rx_hold_left = 60;
        repeat (12) begin
            make_frame($urandom_range(4, 6), FR_GOOD);
            send_frame();
        end
        wait_drain();
        tx_idle_en = 1'b1;
    endtask

    // Frames past 255 bytes: the count saturates while the CRC keeps running.
    task automatic test_long_frames();
        set_min_length(8'd255);
        make_frame(256, FR_GOOD);
        send_frame();
        make_frame(262, FR_CORRUPT);
        send_frame();
        make_frame(20, FR_GOOD);
        send_frame();
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        cfg_we   = 1'b0;
        cfg_data = 8'h00;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_length();
        test_short_and_crc_error();
        test_tiny_frames();
        test_random_frames(8'd4, 120);
        test_random_frames(8'd22, 120);
        test_random_frames(8'($urandom_range(5, 40)), 120);
        test_backpressure();
        test_long_frames();
        test_random_frames(8'd0, 120);

        // Closing stretch at full rate with no idling on either side.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_frames(8'd9, 100);

        wait_drain();
        repeat (8) @(negedge clk);
        if (frame_verdicts_q.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, frame_verdicts_q.size());
            errors++;
        end
        $display("Covered %0d bytes; verdicts seen: %0d good, %0d short, %0d CRC errors.",
                 bytes_accepted, n_good, n_short, n_crc_bad);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
